// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/ftsd_pkg.sv
package ftsd_pkg;

  localparam logic [1:0] CMD_FRAGMENT = 2'd0;
  localparam logic [1:0] CMD_READ     = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  localparam logic [2:0] ST_WRITTEN  = 3'd0;
  localparam logic [2:0] ST_OCCLUDED = 3'd1;
  localparam logic [2:0] ST_OFF      = 3'd2;
  localparam logic [2:0] ST_READ     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  localparam logic [1:0] REG_TEXEL_EVEN = 2'd0;
  localparam logic [1:0] REG_TEXEL_ODD  = 2'd1;
  localparam logic [1:0] REG_FAR_DEPTH  = 2'd2;

  localparam logic signed [15:0] FAR_RESET = 16'sh7FFF;
  localparam logic [7:0] TEXEL_EVEN_RESET = 8'd200;
  localparam logic [7:0] TEXEL_ODD_RESET  = 8'd100;

  // y * width + x for the widest screen
  localparam int ADDR_FULL_W = 15;

  typedef struct packed {
    logic [7:0]         texel_even;
    logic [7:0]         texel_odd;
    logic signed [15:0] far_depth;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] depth;
    logic [7:0]         color;
  } pixel_t;

endpackage

// File: src/ftsd_regs.sv
module ftsd_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ftsd_pkg::cfg_t     cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.texel_even <= ftsd_pkg::TEXEL_EVEN_RESET;
      cfg.texel_odd  <= ftsd_pkg::TEXEL_ODD_RESET;
      cfg.far_depth  <= ftsd_pkg::FAR_RESET;
    end else if (wr) begin
      unique case (paddr[3:2])
        ftsd_pkg::REG_TEXEL_EVEN: cfg.texel_even <= pwdata[7:0];
        ftsd_pkg::REG_TEXEL_ODD:  cfg.texel_odd  <= pwdata[7:0];
        ftsd_pkg::REG_FAR_DEPTH:  cfg.far_depth  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ftsd_pkg::REG_TEXEL_EVEN: prdata = {24'd0, cfg.texel_even};
      ftsd_pkg::REG_TEXEL_ODD:  prdata = {24'd0, cfg.texel_odd};
      ftsd_pkg::REG_FAR_DEPTH:  prdata = {{16{cfg.far_depth[15]}}, cfg.far_depth};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// File: src/ftsd_shade.sv
module ftsd_shade #(
  parameter int TEXTURE_SIZE = 16
) (
  input  logic           clk,
  input  logic           en,
  input  ftsd_pkg::cfg_t cfg,
  input  logic [7:0]     tex_u,
  input  logic [7:0]     tex_v,
  input  logic [7:0]     pos_x,
  input  logic [5:0]     pos_y,
  output logic [7:0]     color
);

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_DIM    = 2'd1;
  localparam logic [1:0] MODE_BRIGHT = 2'd2;

  logic [16:0] u_prod, v_prod;
  logic [8:0]  tx, ty;
  logic [10:0] factor;
  logic [23:0] fq_prod;
  logic [10:0] fq;
  logic [10:0] frem;
  logic [7:0]  texel;
  logic [1:0]  mode;

  logic [7:0]  texel_q;
  logic [1:0]  mode_q;
  logic [11:0] scaled;
  logic [24:0] sq_prod;
  logic [8:0]  sq;

  // texture lookup and position factor, registered on request
  always_comb begin
    u_prod = 17'(tex_u) * 17'(TEXTURE_SIZE);
    v_prod = 17'(tex_v) * 17'(TEXTURE_SIZE);
    tx = u_prod[16:8];
    ty = v_prod[16:8];
    if (tx >= 9'(TEXTURE_SIZE)) tx = 9'(TEXTURE_SIZE - 1);
    if (ty >= 9'(TEXTURE_SIZE)) ty = 9'(TEXTURE_SIZE - 1);
    texel = (tx[2] ^ ty[2]) ? cfg.texel_odd : cfg.texel_even;

    factor  = 11'({pos_x, 1'b0}) + 11'(pos_x) + 11'({pos_y, 3'b000}) - 11'(pos_y);
    // divide by 100 via reciprocal
    fq_prod = 24'(factor) * 24'd5243;
    fq      = 11'(fq_prod >> 19);
    frem    = factor - 11'(fq * 11'd100);
    if (frem < 11'd30)      mode = MODE_DIM;
    else if (frem > 11'd70) mode = MODE_BRIGHT;
    else                    mode = MODE_NONE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      texel_q <= texel;
      mode_q  <= mode;
    end
  end

  // scale by 9/10, 11/10 or 1; divide by 10 via reciprocal
  always_comb begin
    if (mode_q == MODE_DIM) scaled = 12'(texel_q) * 12'd9;
    else                    scaled = 12'(texel_q) * 12'd11;
    sq_prod = 25'(scaled) * 25'd6554;
    sq      = 9'(sq_prod >> 16);
    case (mode_q)
      MODE_DIM:    color = sq[7:0];
      MODE_BRIGHT: color = sq[8] ? 8'hFF : sq[7:0];
      default:     color = texel_q;
    endcase
  end

endmodule

// File: src/ftsd_fb.sv
`include "assert_macros.svh"

module ftsd_fb #(
  parameter int PIXELS = 12000,
  parameter int AW     = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  ftsd_pkg::pixel_t wr_data,
  output ftsd_pkg::pixel_t rd_data,
  output logic             clearing
);

  logic signed [15:0] depth_mem [PIXELS];
  logic [7:0]         color_mem [PIXELS];

  logic [AW-1:0]    clr_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  ftsd_pkg::pixel_t mem_wd;
  ftsd_pkg::pixel_t mem_q;
  logic [AW-1:0]    rd_addr_q;

  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  ftsd_pkg::pixel_t fwd_data;

  // clearing pass after reset, one pixel a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(PIXELS - 1)) clearing <= 1'b0;
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_comb begin
    if (clearing) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd.depth = ftsd_pkg::FAR_RESET;
      mem_wd.color = 8'd0;
    end else begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_wa] <= mem_wd.depth;
      color_mem[mem_wa] <= mem_wd.color;
    end
    if (rd_en) begin
      mem_q.depth <= depth_mem[rd_addr];
      mem_q.color <= color_mem[rd_addr];
      rd_addr_q   <= rd_addr;
    end
  end

  // last write, covers a read issued at the edge of that write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en && !clearing) begin
      fwd_valid <= 1'b1;
      fwd_addr  <= wr_addr;
      fwd_data  <= wr_data;
    end
  end

  assign rd_data = (fwd_valid && fwd_addr == rd_addr_q) ? fwd_data : mem_q;

  `ASSERT_IMPL(a_no_write_while_clearing, clk, rst, clearing, !wr_en && !rd_en)
  `ASSERT_IMPL(a_no_fwd_while_clearing, clk, rst, clearing, !fwd_valid)
  `ASSERT_NEXT(a_clear_done_stays, clk, rst, !clearing, !clearing)

endmodule

// File: src/fragment_texture_shade_depth_test.sv
// Fragment back end: texture sample, position shading and less-than depth test
// against an on-chip framebuffer of SCREEN_WIDTH x SCREEN_HEIGHT pixels.
// Input channel (in_valid/in_ready) carries one command per request:
// fragment, read pixel or clear pixel; command 3 is taken and dropped.
// Output channel (out_valid/out_ready) returns one result per command other
// than 3, with status, color and the stored depth after the access (0 off screen).
// A taken request is registered in stage 1, then in the output register.
// Throughput is one request per cycle while the output does not stall; a
// framebuffer read-modify-write to the same pixel in consecutive requests
// is forwarded from the last write register, so no bubble is inserted.
// The framebuffer is two single-port-write, one-read memories with a
// registered read; the read is issued at the accept edge.
// After reset the framebuffer is cleared one pixel per cycle, all
// SCREEN_WIDTH*SCREEN_HEIGHT pixels (12000 by default); in_ready stays low
// during that pass, configuration writes are taken throughout.
// When the receiver stalls, the result stays in the output register, one
// more request is held in the stage in front of it, then in_ready drops.
// Configuration: APB, texel_even at 0x0, texel_odd at 0x4, far_depth at 0x8.
`include "assert_macros.svh"

module fragment_texture_shade_depth_test #(
  parameter int SCREEN_WIDTH  = 200,
  parameter int SCREEN_HEIGHT = 60,
  parameter int TEXTURE_SIZE  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [7:0]         pos_x,
  input  logic [5:0]         pos_y,
  input  logic signed [15:0] frag_depth,
  input  logic [7:0]         tex_u,
  input  logic [7:0]         tex_v,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [7:0]         pixel_color,
  output logic signed [15:0] pixel_depth
);

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  ftsd_pkg::cfg_t   cfg;
  ftsd_pkg::pixel_t rd_data;
  ftsd_pkg::pixel_t wr_data;
  logic             clearing;

  logic                            accept;
  logic                            on_screen;
  logic [ftsd_pkg::ADDR_FULL_W-1:0] addr_full;
  logic [AW-1:0]                   addr;

  logic               s1_valid;
  logic [1:0]         s1_cmd;
  logic               s1_on;
  logic signed [15:0] s1_z;
  logic [AW-1:0]      s1_addr;
  logic               s1_adv;
  logic [7:0]         shaded;

  logic               wr_en;
  logic [2:0]         res_status;
  logic [7:0]         res_color;
  logic signed [15:0] res_depth;

  ftsd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clearing && (!s1_valid || !out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign on_screen = ({1'b0, pos_x} < 9'(SCREEN_WIDTH)) &&
                     ({1'b0, pos_y} < 7'(SCREEN_HEIGHT));
  assign addr_full = ftsd_pkg::ADDR_FULL_W'(pos_y) *
                     ftsd_pkg::ADDR_FULL_W'(SCREEN_WIDTH) +
                     ftsd_pkg::ADDR_FULL_W'(pos_x);
  assign addr = addr_full[AW-1:0];

  ftsd_shade #(
    .TEXTURE_SIZE (TEXTURE_SIZE)
  ) u_shade (
    .clk   (clk),
    .en    (accept),
    .cfg   (cfg),
    .tex_u (tex_u),
    .tex_v (tex_v),
    .pos_x (pos_x),
    .pos_y (pos_y),
    .color (shaded)
  );

  ftsd_fb #(
    .PIXELS (PIXELS),
    .AW     (AW)
  ) u_fb (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept && on_screen),
    .rd_addr  (addr),
    .wr_en    (wr_en),
    .wr_addr  (s1_addr),
    .wr_data  (wr_data),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (command != ftsd_pkg::CMD_NONE);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= command;
      s1_on   <= on_screen;
      s1_z    <= frag_depth;
      s1_addr <= addr;
    end
  end

  // depth test and result
  always_comb begin
    wr_en        = 1'b0;
    wr_data      = rd_data;
    res_status   = ftsd_pkg::ST_OFF;
    res_color    = 8'd0;
    res_depth    = 16'sd0;
    if (!s1_on) begin
      if (s1_cmd == ftsd_pkg::CMD_FRAGMENT) res_color = shaded;
    end else begin
      unique case (s1_cmd)
        ftsd_pkg::CMD_FRAGMENT: begin
          res_color = shaded;
          if (s1_z < rd_data.depth) begin
            wr_en         = s1_adv;
            wr_data.depth = s1_z;
            wr_data.color = shaded;
            res_status    = ftsd_pkg::ST_WRITTEN;
            res_depth     = s1_z;
          end else begin
            res_status = ftsd_pkg::ST_OCCLUDED;
            res_depth  = rd_data.depth;
          end
        end
        ftsd_pkg::CMD_READ: begin
          res_status = ftsd_pkg::ST_READ;
          res_color  = rd_data.color;
          res_depth  = rd_data.depth;
        end
        ftsd_pkg::CMD_CLEAR: begin
          wr_en         = s1_adv;
          wr_data.depth = cfg.far_depth;
          wr_data.color = 8'd0;
          res_status    = ftsd_pkg::ST_CLEARED;
          res_depth     = cfg.far_depth;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status      <= res_status;
      pixel_color <= res_color;
      pixel_depth <= res_depth;
    end
  end

  `ASSERT_IMPL(a_pipe_empty_while_clearing, clk, rst, clearing, !s1_valid && !out_valid)
  `ASSERT_IMPL(a_write_only_on_screen, clk, rst, wr_en, s1_valid && s1_on)
  `ASSERT_NEXT(a_written_depth_nearer, clk, rst,
               s1_adv && s1_on && s1_cmd == ftsd_pkg::CMD_FRAGMENT && wr_en,
               status == ftsd_pkg::ST_WRITTEN && pixel_depth == $past(s1_z))

endmodule
